### rtl/llpc_pkg.sv
package llpc_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned POS_BITS = 12;
  localparam int unsigned OFFSET_BITS = 13;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned ERR_BITS = ((SAMPLE_BITS > POS_BITS) ? SAMPLE_BITS : POS_BITS) + 1;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = (COEF_BITS > OFFSET_BITS) ? COEF_BITS : OFFSET_BITS;

  // Fixed-point shifts and limits.
  localparam int unsigned ERR_SHIFT = 7;
  localparam int unsigned LAG_ERR_SHIFT = 10;
  localparam int unsigned LAG_FB_SHIFT = 11;
  localparam int DRIVE_MAX = 4095;
  localparam logic [POS_BITS-1:0] TARGET_RESET = POS_BITS'(2048);

  // Only the setpoint bits that a sample can carry take part in the error.
  localparam logic [POS_BITS-1:0] TARGET_MASK =
    (SAMPLE_BITS >= POS_BITS) ? {POS_BITS{1'b1}} : POS_BITS'((1 << SAMPLE_BITS) - 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET      = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_BASE        = 3'd2,
    REG_K_SCALE     = 3'd3,
    REG_K_LAG_ERR   = 3'd4,
    REG_K_LAG_FB    = 3'd5,
    REG_K_DIRECT    = 3'd6
  } cfg_idx_e;

  // Current register contents as seen by the datapath.
  typedef struct packed {
    logic [POS_BITS-1:0]           target;
    logic signed [OFFSET_BITS-1:0] offset;
    logic [POS_BITS-1:0]           base;
    logic signed [COEF_BITS-1:0]   k_scale;
    logic signed [COEF_BITS-1:0]   k_lag_err;
    logic signed [COEF_BITS-1:0]   k_lag_fb;
    logic signed [COEF_BITS-1:0]   k_direct;
  } cfg_t;

  // Sequencer states; one product is issued in each multiply state.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_LAG_ERR,
    S_LAG_FB,
    S_DIRECT,
    S_SUM,
    S_OUT
  } ctrl_state_e;

endpackage

### rtl/llpc_cfg.sv
module llpc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [llpc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [llpc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output llpc_pkg::cfg_t                      cfg_o
);

  llpc_pkg::cfg_t cfg_q;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= llpc_pkg::TARGET_RESET;
      cfg_q.offset    <= '0;
      cfg_q.base      <= '0;
      cfg_q.k_scale   <= '0;
      cfg_q.k_lag_err <= '0;
      cfg_q.k_lag_fb  <= '0;
      cfg_q.k_direct  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        llpc_pkg::REG_TARGET:    cfg_q.target    <= cfg_data_i[llpc_pkg::POS_BITS-1:0];
        llpc_pkg::REG_OFFSET:    cfg_q.offset    <= signed'(cfg_data_i[llpc_pkg::OFFSET_BITS-1:0]);
        llpc_pkg::REG_BASE:      cfg_q.base      <= cfg_data_i[llpc_pkg::POS_BITS-1:0];
        llpc_pkg::REG_K_SCALE:   cfg_q.k_scale   <= signed'(cfg_data_i[llpc_pkg::COEF_BITS-1:0]);
        llpc_pkg::REG_K_LAG_ERR: cfg_q.k_lag_err <= signed'(cfg_data_i[llpc_pkg::COEF_BITS-1:0]);
        llpc_pkg::REG_K_LAG_FB:  cfg_q.k_lag_fb  <= signed'(cfg_data_i[llpc_pkg::COEF_BITS-1:0]);
        llpc_pkg::REG_K_DIRECT:  cfg_q.k_direct  <= signed'(cfg_data_i[llpc_pkg::COEF_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/llpc_mul.sv
module llpc_mul (
  input  logic                                 clk_i,
  input  logic signed [llpc_pkg::DATA_BITS-1:0] a_i,
  input  logic signed [llpc_pkg::COEF_BITS-1:0] b_i,
  output logic signed [llpc_pkg::DATA_BITS-1:0] p_o
);

  logic signed [llpc_pkg::DATA_BITS+llpc_pkg::COEF_BITS-1:0] full;
  logic signed [llpc_pkg::DATA_BITS-1:0] p_q;

  // Signed product; only the low word is kept, so results wrap as 32-bit values.
  assign full = a_i * b_i;

  // Product register, loaded every cycle.
  always_ff @(posedge clk_i) begin
    p_q <= full[llpc_pkg::DATA_BITS-1:0];
  end

  assign p_o = p_q;

endmodule

### rtl/lead_lag_position_controller_top.sv
// Lead-lag position controller.
// Input channel: in_valid_i/in_ready_o with one position sample per transaction.
// Output channel: out_valid_o/out_ready_i with the clamped drive code and the
// reference code (the base level) of that sample, one result per input.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index and data;
// cfg_ready_o is always high, and a write to an unused index is dropped.
// Configuration is to be written only while no sample is in flight.
// Between acceptance and a loaded result register, the four products of the
// control law go one after another through a single shared 32 x 16 multiplier,
// then one step adds them up and one step clamps and loads the result. A new
// sample is accepted only in the idle step, so the block takes no new sample
// before the last one has gone through all of these steps.
// The result register holds its transaction while the receiver stalls; the
// next sample can be accepted meanwhile, and the sequencer waits in its last
// step until the held result has been taken.
// Reset returns the setpoint to 2048, clears the other registers and clears the
// stored scaled error and lag term.
module lead_lag_position_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [llpc_pkg::SAMPLE_BITS-1:0]    position_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [llpc_pkg::POS_BITS-1:0]       drive_code_o,
  output logic [llpc_pkg::POS_BITS-1:0]       reference_code_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [llpc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [llpc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned DW = llpc_pkg::DATA_BITS;
  localparam int unsigned EW = llpc_pkg::ERR_BITS;
  localparam int unsigned OBW = llpc_pkg::OFFSET_BITS + 1;

  llpc_pkg::cfg_t cfg;
  llpc_pkg::ctrl_state_e state_q, state_d;

  logic [llpc_pkg::SAMPLE_BITS-1:0] sample_q;
  logic signed [DW-1:0] e_q, lag_q, acc_q, prev_e_q, prev_lag_q;
  logic [llpc_pkg::POS_BITS-1:0] drive_q, ref_q;
  logic out_valid_q;

  logic signed [DW-1:0] mul_a, prod;
  logic signed [llpc_pkg::COEF_BITS-1:0] mul_b;
  logic [EW-2:0] sample_ext, target_ext;
  logic signed [EW-1:0] err;
  logic signed [OBW-1:0] off_base;
  logic signed [DW-1:0] sum_w;
  logic [llpc_pkg::POS_BITS-1:0] drive_w;
  logic out_free, out_load;

  // Configuration registers.
  llpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Shared multiplier.
  llpc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Position error, measurement minus setpoint.
  assign sample_ext = (EW-1)'(sample_q);
  assign target_ext = (EW-1)'(cfg.target & llpc_pkg::TARGET_MASK);
  assign err = signed'({1'b0, sample_ext}) - signed'({1'b0, target_ext});

  // Offset plus base level, exact in a narrow word.
  assign off_base = OBW'(cfg.offset) + signed'(OBW'(cfg.base));
  assign sum_w = acc_q + DW'(off_base);

  // Clamp the wrapped sum to the code range.
  always_comb begin
    if (sum_w[DW-1]) begin
      drive_w = '0;
    end else if (sum_w > DW'(llpc_pkg::DRIVE_MAX)) begin
      drive_w = llpc_pkg::POS_BITS'(llpc_pkg::DRIVE_MAX);
    end else begin
      drive_w = sum_w[llpc_pkg::POS_BITS-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      llpc_pkg::S_IDLE:    if (in_valid_i) state_d = llpc_pkg::S_SCALE;
      llpc_pkg::S_SCALE:   state_d = llpc_pkg::S_LAG_ERR;
      llpc_pkg::S_LAG_ERR: state_d = llpc_pkg::S_LAG_FB;
      llpc_pkg::S_LAG_FB:  state_d = llpc_pkg::S_DIRECT;
      llpc_pkg::S_DIRECT:  state_d = llpc_pkg::S_SUM;
      llpc_pkg::S_SUM:     state_d = llpc_pkg::S_OUT;
      llpc_pkg::S_OUT:     if (out_free) state_d = llpc_pkg::S_IDLE;
      default:             state_d = llpc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and result load.
  always_comb begin
    in_ready_o = 1'b0;
    out_load = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      llpc_pkg::S_IDLE: in_ready_o = 1'b1;
      llpc_pkg::S_SCALE: begin
        mul_a = DW'(err);
        mul_b = cfg.k_scale;
      end
      llpc_pkg::S_LAG_ERR: begin
        mul_a = prev_e_q;
        mul_b = cfg.k_lag_err;
      end
      llpc_pkg::S_LAG_FB: begin
        mul_a = prev_lag_q;
        mul_b = cfg.k_lag_fb;
      end
      llpc_pkg::S_DIRECT: begin
        mul_a = e_q;
        mul_b = cfg.k_direct;
      end
      llpc_pkg::S_OUT: out_load = out_free;
      default: begin
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llpc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      prev_e_q <= '0;
      prev_lag_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == llpc_pkg::S_SUM) begin
        prev_e_q <= e_q;
        prev_lag_q <= lag_q;
      end
    end
  end

  // Datapath registers; each product is taken in the state after the one that issues it.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= position_sample_i;
    end
    case (state_q)
      llpc_pkg::S_LAG_ERR: e_q <= prod >>> llpc_pkg::ERR_SHIFT;
      llpc_pkg::S_LAG_FB:  lag_q <= prod >>> llpc_pkg::LAG_ERR_SHIFT;
      llpc_pkg::S_DIRECT:  lag_q <= lag_q + (prod >>> llpc_pkg::LAG_FB_SHIFT);
      llpc_pkg::S_SUM:     acc_q <= prod + lag_q;
      default: begin
      end
    endcase
    if (out_load) begin
      drive_q <= drive_w;
      ref_q <= cfg.base;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_code_o = drive_q;
  assign reference_code_o = ref_q;

  // An accepted sample starts the multiply sequence.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == llpc_pkg::S_SCALE))
    else $error("accepted sample did not start the sequence");

  // A result only appears from the final sequencer step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == llpc_pkg::S_OUT))
    else $error("result appeared outside the final step");

  // A negative sum saturates the drive to zero.
  a_clamp_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && sum_w[DW-1]) |=> (drive_code_o == '0))
    else $error("negative sum not clamped to zero");

endmodule

### dv/llpc_drive_checker.sv
module llpc_drive_checker
  import llpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [SAMPLE_BITS-1:0]   position_sample_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [POS_BITS-1:0]      drive_code_i,
  input  logic [POS_BITS-1:0]      reference_code_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  // One drive transaction as the block should present it.
  typedef struct packed {
    logic [POS_BITS-1:0] drive;
    logic [POS_BITS-1:0] reference;
  } drive_result_t;

  // Shadow copy of the register file, coefficients widened to the datapath.
  logic [POS_BITS-1:0]         setpoint;
  logic signed [DATA_BITS-1:0] offset_ext;
  logic [POS_BITS-1:0]         base_lvl;
  logic signed [DATA_BITS-1:0] k_scale;
  logic signed [DATA_BITS-1:0] k_lag_err;
  logic signed [DATA_BITS-1:0] k_lag_fb;
  logic signed [DATA_BITS-1:0] k_direct;

  // Loop memory carried from one sample to the next.
  logic signed [DATA_BITS-1:0] last_scaled_err;
  logic signed [DATA_BITS-1:0] last_lag_term;

  drive_result_t expected_drive_q[$];
  int unsigned   mismatches;
  int unsigned   checked;

  // Runs the control law for one sample, wrapping at 32 bits, and advances the loop memory.
  function automatic drive_result_t control_law_step(input logic [SAMPLE_BITS-1:0] pos);
    logic signed [DATA_BITS-1:0] err;
    logic signed [DATA_BITS-1:0] prod;
    logic signed [DATA_BITS-1:0] scaled;
    logic signed [DATA_BITS-1:0] direct;
    logic signed [DATA_BITS-1:0] lag;
    logic signed [DATA_BITS-1:0] total;
    drive_result_t               res;
    err    = DATA_BITS'(pos) - DATA_BITS'(setpoint & TARGET_MASK);
    prod   = k_scale * err;
    scaled = prod >>> ERR_SHIFT;
    direct = scaled * k_direct;
    prod   = last_scaled_err * k_lag_err;
    lag    = prod >>> LAG_ERR_SHIFT;
    prod   = last_lag_term * k_lag_fb;
    lag    = lag + (prod >>> LAG_FB_SHIFT);
    total  = direct + lag + offset_ext + DATA_BITS'(base_lvl);
    // The clamp looks at the wrapped signed sum.
    if (total < 0) begin
      res.drive = '0;
    end else if (total > DRIVE_MAX) begin
      res.drive = POS_BITS'(DRIVE_MAX);
    end else begin
      res.drive = total[POS_BITS-1:0];
    end
    res.reference   = base_lvl;
    last_scaled_err = scaled;
    last_lag_term   = lag;
    return res;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endfunction

  // Follow every transaction on the three channels at the clock edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    drive_result_t want;
    if (!rst_ni) begin
      setpoint        = TARGET_RESET;
      offset_ext      = '0;
      base_lvl        = '0;
      k_scale         = '0;
      k_lag_err       = '0;
      k_lag_fb        = '0;
      k_direct        = '0;
      last_scaled_err = '0;
      last_lag_term   = '0;
      expected_drive_q.delete();
      mismatches = 0;
      checked    = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      // Register writes; bits above a register's width and unused indexes are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TARGET:    setpoint   = cfg_data_i[POS_BITS-1:0];
          REG_OFFSET:    offset_ext = $signed(cfg_data_i[OFFSET_BITS-1:0]);
          REG_BASE:      base_lvl   = cfg_data_i[POS_BITS-1:0];
          REG_K_SCALE:   k_scale    = $signed(cfg_data_i[COEF_BITS-1:0]);
          REG_K_LAG_ERR: k_lag_err  = $signed(cfg_data_i[COEF_BITS-1:0]);
          REG_K_LAG_FB:  k_lag_fb   = $signed(cfg_data_i[COEF_BITS-1:0]);
          REG_K_DIRECT:  k_direct   = $signed(cfg_data_i[COEF_BITS-1:0]);
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_drive_q.size() == 0) begin
          note_mismatch($sformatf("drive %0d ref %0d arrived with no sample outstanding",
                                  drive_code_i, reference_code_i));
        end else begin
          want = expected_drive_q.pop_front();
          if (want.drive !== drive_code_i || want.reference !== reference_code_i) begin
            note_mismatch($sformatf("expected drive %0d ref %0d, got drive %0d ref %0d",
                                    want.drive, want.reference,
                                    drive_code_i, reference_code_i));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_drive_q.push_back(control_law_step(position_sample_i));
      end

      mismatch_count_o <= mismatches;
      pending_o        <= expected_drive_q.size();
      checked_o        <= checked;
    end
  end

endmodule

### dv/lead_lag_position_controller_top_tb.sv
module lead_lag_position_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llpc_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE        = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 90;
  localparam int TIMEOUT_NS    = 10_000_000;

  // Index past the last register; writes to it must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SAMPLE_BITS-1:0]   position_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [POS_BITS-1:0]      drive_code;
  logic [POS_BITS-1:0]      reference_code;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned checked_results;

  int unsigned         hold_req = 0;
  int unsigned         samples_sent = 0;
  int unsigned         reg_writes = 0;
  int unsigned         settings_used = 0;
  logic [POS_BITS-1:0] cur_target = TARGET_RESET;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  lead_lag_position_controller_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .position_sample_i (position_sample),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .drive_code_o      (drive_code),
    .reference_code_o  (reference_code),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  llpc_drive_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .position_sample_i (position_sample),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .drive_code_i      (drive_code),
    .reference_code_i  (reference_code),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending_results),
    .checked_o         (checked_results)
  );

  // Offers one register write and returns at the edge that takes the transaction.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // Writes a full gain set; unused upper data bits carry noise that must be ignored.
  task automatic program_gains(input logic [POS_BITS-1:0] target,
                               input logic signed [OFFSET_BITS-1:0] offset,
                               input logic [POS_BITS-1:0] base,
                               input logic signed [COEF_BITS-1:0] ks,
                               input logic signed [COEF_BITS-1:0] kle,
                               input logic signed [COEF_BITS-1:0] klf,
                               input logic signed [COEF_BITS-1:0] kd);
    write_reg(REG_TARGET, {4'($urandom), target});
    write_reg(REG_OFFSET, {3'($urandom), offset});
    write_reg(REG_BASE, {4'($urandom), base});
    write_reg(REG_K_SCALE, ks);
    write_reg(REG_K_LAG_ERR, kle);
    write_reg(REG_K_LAG_FB, klf);
    write_reg(REG_K_DIRECT, kd);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_UNUSED, 16'($urandom));
    end
    cfg_valid  <= 1'b0;
    cur_target = target;
    settings_used++;
  endtask

  // Offers one sample and returns at the edge that takes the transaction.
  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] pos);
    in_valid        <= 1'b1;
    position_sample <= pos;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Lets every outstanding result come back before the registers change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [COEF_BITS-1:0] coef_extreme();
    return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  // Bursts of samples, mostly near the setpoint, with random gaps between bursts.
  task automatic send_random(input int count);
    int burst_left;
    int gap;
    int pick;
    int pos;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        pos = int'(cur_target) + int'($urandom_range(0, 400)) - 200;
        if (pos < 0) pos = 0;
        if (pos > 4095) pos = 4095;
      end else if (pick < 9) begin
        pos = $urandom_range(0, 4095);
      end else begin
        pos = ($urandom_range(0, 1) == 1) ? 4095 : 0;
      end
      drive_sample(SAMPLE_BITS'(pos));
      burst_left--;
    end
  endtask

  // Receiver: stretches of always ready, random, mostly stalled and mostly ready, plus long
  // hold-offs on request while the sender keeps offering samples.
  initial begin : receiver
    int          mode;
    int          span;
    int unsigned hold_served;
    hold_served = 0;
    forever begin
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        repeat (span) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int                     mode;
    logic [SAMPLE_BITS-1:0] pts[$];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all gains zero, so the drive is zero.
    pts = '{12'd0, 12'd4095};
    foreach (pts[i]) drive_sample(pts[i]);

    // Unity loop: zero error, both rails and alternating bit patterns.
    drain();
    program_gains(12'd2048, 13'sd0, 12'd2048, 16'sd128, 16'sd512, 16'sd1024, 16'sd1);
    pts = '{12'd2048, 12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd2100, 12'd2000};
    foreach (pts[i]) drive_sample(pts[i]);

    // Largest gains, offset and base with a zero setpoint: products and sums wrap.
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    program_gains(12'd0, 13'sd4095, 12'd4095, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    pts = '{12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4095};
    foreach (pts[i]) drive_sample(pts[i]);

    // Most negative gains, zero base, a large negative offset and the top setpoint.
    drain();
    write_reg(REG_UNUSED, 16'h0000);
    program_gains(12'd4095, -13'sd4095, 12'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    pts = '{12'd0, 12'd4095, 12'd0, 12'd2047, 12'd0};
    foreach (pts[i]) drive_sample(pts[i]);

    // Pure proportional drive, pushed into the upper clamp limit by the top sample.
    drain();
    program_gains(12'd2048, 13'sd1, 12'd4095, 16'sd128, 16'sd0, 16'sd0, 16'sd1);
    pts = '{12'd0, 12'd4095};
    foreach (pts[i]) drive_sample(pts[i]);

    // Random phases: half plausible loop tunings, a quarter full-range and a quarter extremes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      mode = phase % 4;
      case (mode)
        2: program_gains(12'($urandom), 13'(int'($urandom_range(0, 8190)) - 4095),
                         12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
        3: program_gains(($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0,
                         ($urandom_range(0, 1) == 1) ? 13'sd4095 : -13'sd4095,
                         ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0,
                         coef_extreme(), coef_extreme(), coef_extreme(), coef_extreme());
        default: program_gains(12'($urandom),
                               13'(int'($urandom_range(0, 2000)) - 1000),
                               12'($urandom),
                               16'(int'($urandom_range(0, 384)) - 192),
                               16'(int'($urandom_range(0, 2048)) - 1024),
                               16'(int'($urandom_range(0, 4094)) - 2047),
                               16'(int'($urandom_range(0, 6)) - 3));
      endcase
      // Stall the receiver for a long stretch so the block backs up into its input.
      if (phase == 1 || phase == 9) begin
        hold_req <= hold_req + 1;
      end
      send_random(PHASE_ITEMS);
    end

    drain();
    $display("Run covered %0d samples under %0d gain settings (%0d register writes).",
             samples_sent, settings_used, reg_writes);
    $display("%0d results checked; receiver held off %0d times for %0d cycles each.",
             checked_results, hold_req, LONG_HOLD);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("lead_lag_position_controller_top_tb: PASS");
    end else begin
      $display("lead_lag_position_controller_top_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Timed out with %0d results outstanding.", pending_results);
    $display("lead_lag_position_controller_top_tb: FAIL");
    $finish;
  end

endmodule
